// ===== rtl/fxm_pkg.sv =====
package fxm_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int DIM        = 4;
  localparam int CELLS      = DIM * DIM;
  localparam int IDX_W      = $clog2(CELLS);
  localparam int DIM_W      = $clog2(DIM);
  localparam int KIND_W     = 2;
  localparam int PROD_W     = 2 * DATA_WIDTH;
  // Four products need two guard bits above the product width.
  localparam int ACC_W      = PROD_W + 2;
  localparam int STEP_W     = IDX_W + DIM_W;

  typedef logic signed [DATA_WIDTH-1:0] elem_t;
  typedef logic [IDX_W-1:0]             idx_t;
  typedef logic [KIND_W-1:0]            kind_bits_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_LEFT    = 2'd0,
    KIND_RIGHT   = 2'd1,
    KIND_COMPUTE = 2'd2
  } kind_t;

  localparam elem_t ELEM_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam elem_t ELEM_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam idx_t  IDX_LAST = idx_t'(CELLS - 1);

  // Sideband that travels with each multiply-accumulate through the pipeline.
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
    idx_t index;
  } mac_tag_t;

  typedef struct packed {
    logic  en;
    logic  sel_right;
    idx_t  addr;
    elem_t data;
  } wr_req_t;

endpackage

// ===== rtl/fxm_in_if.sv =====
interface fxm_in_if;
  logic                  valid;
  logic                  ready;
  fxm_pkg::kind_bits_t   kind;
  fxm_pkg::idx_t         element_index;
  fxm_pkg::elem_t        element_value;

  modport source (output valid, kind, element_index, element_value, input ready);
  modport sink (input valid, kind, element_index, element_value, output ready);
endinterface

// ===== rtl/fxm_out_if.sv =====
interface fxm_out_if;
  logic             valid;
  logic             ready;
  fxm_pkg::idx_t    result_index;
  fxm_pkg::elem_t   product_value;
  logic             last_element;

  modport source (output valid, result_index, product_value, last_element, input ready);
  modport sink (input valid, result_index, product_value, last_element, output ready);
endinterface

// ===== rtl/matrix4x4_multiply_fixed.sv =====
// Column-major 4x4 fixed-point matrix product (left times right) in signed Q16.16. A load
// word writes one element of the left or right matrix. A compute word keeps in_ch.ready low
// until all its multiply-accumulates have been issued, one per cycle while the output does
// not stall, through a single shared 32x32 multiplier; the sixteen result words follow in
// index order, the last one flagged by last_element. Each result is the exact sum of four
// products, shifted right by 16 with floor rounding and saturated to 32 bits. While a result
// waits on out_ch.ready the whole multiply pipeline holds.
module matrix4x4_multiply_fixed (
  input logic        clk,
  input logic        rst_n,
  fxm_in_if.sink     in_ch,
  fxm_out_if.source  out_ch
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  localparam logic [fxm_pkg::STEP_W-1:0] STEP_LAST =
    fxm_pkg::STEP_W'(fxm_pkg::CELLS * fxm_pkg::DIM - 1);
  localparam logic [fxm_pkg::DIM_W-1:0] J_LAST = fxm_pkg::DIM_W'(fxm_pkg::DIM - 1);

  state_t                        state_r, state_nxt;
  logic [fxm_pkg::STEP_W-1:0]    step_r, step_nxt;
  logic                          en;
  logic                          accept;
  logic [fxm_pkg::DIM_W-1:0]     j, r, c;
  fxm_pkg::wr_req_t              wr;
  fxm_pkg::mac_tag_t             tag1_r;
  fxm_pkg::elem_t                left_data, right_data;
  logic                          res_valid;
  fxm_pkg::idx_t                 res_index;
  fxm_pkg::elem_t                res_value;
  logic                          out_valid_r;
  fxm_pkg::idx_t                 out_index_r;
  fxm_pkg::elem_t                out_value_r;
  logic                          out_last_r;

  assign en     = !out_valid_r || out_ch.ready;
  assign accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE);

  assign wr.en        = accept && (in_ch.kind == fxm_pkg::KIND_LEFT ||
                                   in_ch.kind == fxm_pkg::KIND_RIGHT);
  assign wr.sel_right = (in_ch.kind == fxm_pkg::KIND_RIGHT);
  assign wr.addr      = in_ch.element_index;
  assign wr.data      = in_ch.element_value;

  // Step counter splits into column, row and inner index.
  assign j = step_r[fxm_pkg::DIM_W-1:0];
  assign r = step_r[2*fxm_pkg::DIM_W-1:fxm_pkg::DIM_W];
  assign c = step_r[3*fxm_pkg::DIM_W-1:2*fxm_pkg::DIM_W];

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && in_ch.kind == fxm_pkg::KIND_COMPUTE) begin
          state_nxt = ST_RUN;
          step_nxt  = '0;
        end
      end
      ST_RUN: begin
        if (en) begin
          step_nxt = step_r + 1'b1;
          if (step_r == STEP_LAST) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
      tag1_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      if (en) begin
        tag1_r.valid <= (state_r == ST_RUN);
        tag1_r.first <= (j == '0);
        tag1_r.last  <= (j == J_LAST);
        tag1_r.index <= step_r[fxm_pkg::STEP_W-1:fxm_pkg::DIM_W];
      end
    end
  end

  fxm_store u_store (
    .clk          (clk),
    .wr           (wr),
    .rd_en        (en),
    .rd_addr_l    ({j, r}),
    .rd_addr_r    ({c, j}),
    .left_data_r  (left_data),
    .right_data_r (right_data)
  );

  fxm_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .tag_in    (tag1_r),
    .a         (left_data),
    .b         (right_data),
    .res_valid (res_valid),
    .res_index (res_index),
    .res_value (res_value)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_index_r <= res_index;
      out_value_r <= res_value;
      out_last_r  <= (res_index == fxm_pkg::IDX_LAST);
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.result_index  = out_index_r;
  assign out_ch.product_value = out_value_r;
  assign out_ch.last_element  = out_last_r;

endmodule

// ===== rtl/fxm_store.sv =====
module fxm_store (
  input  logic             clk,
  input  fxm_pkg::wr_req_t wr,
  input  logic             rd_en,
  input  fxm_pkg::idx_t    rd_addr_l,
  input  fxm_pkg::idx_t    rd_addr_r,
  output fxm_pkg::elem_t   left_data_r,
  output fxm_pkg::elem_t   right_data_r
);

  fxm_pkg::elem_t left_mem_r  [fxm_pkg::CELLS];
  fxm_pkg::elem_t right_mem_r [fxm_pkg::CELLS];

  always_ff @(posedge clk) begin
    if (wr.en && !wr.sel_right) begin
      left_mem_r[wr.addr] <= wr.data;
    end
    if (wr.en && wr.sel_right) begin
      right_mem_r[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      left_data_r  <= left_mem_r[rd_addr_l];
      right_data_r <= right_mem_r[rd_addr_r];
    end
  end

endmodule

// ===== rtl/fxm_mac.sv =====
module fxm_mac (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  fxm_pkg::mac_tag_t  tag_in,
  input  fxm_pkg::elem_t     a,
  input  fxm_pkg::elem_t     b,
  output logic               res_valid,
  output fxm_pkg::idx_t      res_index,
  output fxm_pkg::elem_t     res_value
);

  fxm_pkg::mac_tag_t                    tag2_r;
  logic signed [fxm_pkg::PROD_W-1:0]    prod_r;
  logic signed [fxm_pkg::ACC_W-1:0]     acc_r;
  logic signed [fxm_pkg::ACC_W-1:0]     acc_nxt;
  logic signed [fxm_pkg::ACC_W-1:0]     scaled;
  logic                                 done_r;
  fxm_pkg::idx_t                        done_idx_r;
  logic [fxm_pkg::ACC_W-fxm_pkg::DATA_WIDTH:0] upper;
  logic                                 fits;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag2_r <= '0;
      done_r <= 1'b0;
    end else if (en) begin
      tag2_r <= tag_in;
      done_r <= tag2_r.valid && tag2_r.last;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r     <= a * b;
      acc_r      <= acc_nxt;
      done_idx_r <= tag2_r.index;
    end
  end

  assign acc_nxt = (tag2_r.first ? '0 : acc_r) + fxm_pkg::ACC_W'(prod_r);

  // The finished sum sits in acc_r for exactly the cycle in which done_r is set.
  assign scaled = acc_r >>> fxm_pkg::FRAC_BITS;
  assign upper  = scaled[fxm_pkg::ACC_W-1:fxm_pkg::DATA_WIDTH-1];
  assign fits   = (&upper) || !(|upper);

  assign res_valid = done_r;
  assign res_index = done_idx_r;
  assign res_value = fits ? scaled[fxm_pkg::DATA_WIDTH-1:0]
                          : (acc_r[fxm_pkg::ACC_W-1] ? fxm_pkg::ELEM_MIN : fxm_pkg::ELEM_MAX);

endmodule

// ===== rtl/fxm_checker.sv =====
module fxm_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input fxm_pkg::kind_bits_t in_kind,
  input logic                out_valid,
  input logic                out_ready,
  input fxm_pkg::idx_t       out_index,
  input fxm_pkg::elem_t      out_value,
  input logic                out_last
);

  // A result word that is not taken stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_index) && $stable(out_value))
    else $error("result word changed while stalled");

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == (out_index == fxm_pkg::IDX_LAST)))
    else $error("last_element does not match the final index");

  a_compute_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_kind == fxm_pkg::KIND_COMPUTE |=> !in_ready)
    else $error("input still ready after a compute word");

  // Once in_ready falls for a compute, it does not rise again straight away.
  a_busy_span: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_ready) |=> !in_ready)
    else $error("compute finished too early");

endmodule

bind matrix4x4_multiply_fixed fxm_checker u_fxm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_kind   (in_ch.kind),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_index (out_ch.result_index),
  .out_value (out_ch.product_value),
  .out_last  (out_ch.last_element)
);

// ===== bench/tb_matrix4x4_multiply_fixed.sv =====
module tb_matrix4x4_multiply_fixed;

  localparam fxm_pkg::kind_bits_t KIND_UNUSED = 2'd3;
  localparam int RANDOM_WORDS = 220;
  localparam int IDLE_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 100;
  localparam int WIDE_W = 2 * fxm_pkg::DATA_WIDTH + 4;
  localparam fxm_pkg::elem_t ONE_Q16 = fxm_pkg::elem_t'(1 << fxm_pkg::FRAC_BITS);
  localparam logic signed [WIDE_W-1:0] SAT_HIGH = fxm_pkg::ELEM_MAX;
  localparam logic signed [WIDE_W-1:0] SAT_LOW = fxm_pkg::ELEM_MIN;

  typedef struct packed {
    fxm_pkg::idx_t  index;
    fxm_pkg::elem_t value;
    logic           last;
  } product_t;

  typedef struct packed {
    fxm_pkg::kind_bits_t kind;
    logic                fill;
    fxm_pkg::idx_t       index;
    fxm_pkg::elem_t      value;
    logic                typed;
    fxm_pkg::elem_t      want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  fxm_in_if  in_ch ();
  fxm_out_if out_ch ();

  matrix4x4_multiply_fixed i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  fxm_pkg::elem_t left_elem [fxm_pkg::CELLS];
  fxm_pkg::elem_t right_elem [fxm_pkg::CELLS];
  product_t       product_q [$];
  stim_row_t      stim_rows [$];
  int             mismatches = 0;
  int             idle_cycles = 0;
  int             stall_left = 0;
  int             rx_timer = 0;
  bit             rx_burst = 1'b0;
  bit             tx_burst = 1'b0;

  task automatic report_mismatch(string what, logic [fxm_pkg::DATA_WIDTH-1:0] got,
                                 logic [fxm_pkg::DATA_WIDTH-1:0] want);
    mismatches++;
    $display("%0t: %s: got %h, want %h", $time, what, got, want);
  endtask

  function automatic int idle_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic fxm_pkg::elem_t pick_value();
    case ($urandom_range(0, 5))
      0, 1: return fxm_pkg::elem_t'($urandom_range(0, 32'h0008_0000) - 32'h0004_0000);
      2: return fxm_pkg::elem_t'($urandom());
      3: return $urandom_range(0, 1)
                ? fxm_pkg::ELEM_MAX - fxm_pkg::elem_t'($urandom_range(0, 3))
                : fxm_pkg::ELEM_MIN + fxm_pkg::elem_t'($urandom_range(0, 3));
      4: return fxm_pkg::elem_t'($signed(8'($urandom()))) <<< fxm_pkg::FRAC_BITS;
      default: return fxm_pkg::elem_t'($urandom_range(0, 32'h0003_FFFF) - 32'h0002_0000);
    endcase
  endfunction

  // Exact sum of four products, floor shift, then clamp to the element range.
  function automatic fxm_pkg::elem_t product_element(int col, int row);
    logic signed [WIDE_W-1:0] acc, lhs, rhs, scaled;
    acc = '0;
    for (int j = 0; j < fxm_pkg::DIM; j++) begin
      lhs = left_elem[fxm_pkg::DIM*j + row];
      rhs = right_elem[fxm_pkg::DIM*col + j];
      acc = acc + lhs * rhs;
    end
    scaled = acc >>> fxm_pkg::FRAC_BITS;
    if (scaled > SAT_HIGH) return fxm_pkg::ELEM_MAX;
    if (scaled < SAT_LOW) return fxm_pkg::ELEM_MIN;
    return fxm_pkg::elem_t'(scaled);
  endfunction

  task automatic predict_product();
    int k;
    for (int c = 0; c < fxm_pkg::DIM; c++) begin
      for (int r = 0; r < fxm_pkg::DIM; r++) begin
        k = fxm_pkg::DIM*c + r;
        product_q.push_back('{index: fxm_pkg::idx_t'(k), value: product_element(c, r),
                              last: (k == fxm_pkg::CELLS - 1)});
      end
    end
  endtask

  task automatic track_word(fxm_pkg::kind_bits_t kind, fxm_pkg::idx_t index,
                            fxm_pkg::elem_t value);
    case (kind)
      fxm_pkg::KIND_LEFT: left_elem[index] = value;
      fxm_pkg::KIND_RIGHT: right_elem[index] = value;
      fxm_pkg::KIND_COMPUTE: predict_product();
      default: ;
    endcase
  endtask

  // Called just after the clock rises; returns as soon as the word has been taken.
  task automatic send_word(fxm_pkg::kind_bits_t kind, fxm_pkg::idx_t index,
                           fxm_pkg::elem_t value);
    int gap;
    gap = tx_burst ? 0 : idle_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind <= kind;
    in_ch.element_index <= index;
    in_ch.element_value <= value;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
  endtask

  task automatic add_row(fxm_pkg::kind_bits_t kind, logic fill, fxm_pkg::idx_t index,
                         fxm_pkg::elem_t value, logic typed, fxm_pkg::elem_t want);
    stim_rows.push_back('{kind: kind, fill: fill, index: index, value: value,
                          typed: typed, want: want});
  endtask

  task automatic check_product();
    product_t want;
    if (product_q.size() == 0) begin
      report_mismatch("result word with nothing expected", out_ch.product_value, '0);
    end else begin
      want = product_q.pop_front();
      if (out_ch.result_index !== want.index)
        report_mismatch("result_index", out_ch.result_index, want.index);
      if (out_ch.product_value !== want.value)
        report_mismatch("product_value", out_ch.product_value, want.value);
      if (out_ch.last_element !== want.last)
        report_mismatch("last_element", out_ch.last_element, want.last);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      check_product();
    end
    if (rx_timer == 0) begin
      rx_burst = ($urandom_range(0, 5) == 0);
      rx_timer = $urandom_range(50, 300);
    end else begin
      rx_timer--;
    end
    if (stall_left == 0 && !rx_burst && $urandom_range(0, 3) == 0) begin
      stall_left = idle_len();
    end
    if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left--;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    stim_row_t           row;
    fxm_pkg::kind_bits_t kind;
    fxm_pkg::idx_t       index;
    fxm_pkg::elem_t      value;
    int                  count;
    int                  roll;
    bit                  paused;

    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.kind = fxm_pkg::KIND_LEFT;
    in_ch.element_index = '0;
    in_ch.element_value = '0;
    out_ch.ready = 1'b0;

    // Every element gets written before the first compute word.
    add_row(fxm_pkg::KIND_LEFT, 1'b1, '0, ONE_Q16, 1'b0, '0);
    add_row(fxm_pkg::KIND_RIGHT, 1'b1, '0, ONE_Q16, 1'b0, '0);
    add_row(fxm_pkg::KIND_COMPUTE, 1'b0, '0, '0, 1'b1,
            fxm_pkg::elem_t'(4 << fxm_pkg::FRAC_BITS));
    add_row(KIND_UNUSED, 1'b0, fxm_pkg::IDX_LAST, fxm_pkg::ELEM_MIN, 1'b0, '0);
    add_row(fxm_pkg::KIND_COMPUTE, 1'b0, fxm_pkg::IDX_LAST, fxm_pkg::elem_t'(-1), 1'b1,
            fxm_pkg::elem_t'(4 << fxm_pkg::FRAC_BITS));
    add_row(fxm_pkg::KIND_RIGHT, 1'b1, '0, fxm_pkg::elem_t'(1), 1'b0, '0);
    add_row(fxm_pkg::KIND_COMPUTE, 1'b0, '0, '0, 1'b1, fxm_pkg::elem_t'(4));
    // Four products of one LSB each still round down to zero.
    add_row(fxm_pkg::KIND_LEFT, 1'b1, '0, fxm_pkg::elem_t'(1), 1'b0, '0);
    add_row(fxm_pkg::KIND_COMPUTE, 1'b0, '0, '0, 1'b1, '0);
    // A tiny negative sum floors to minus one LSB, not to zero.
    add_row(fxm_pkg::KIND_LEFT, 1'b1, '0, fxm_pkg::elem_t'(-1), 1'b0, '0);
    add_row(fxm_pkg::KIND_COMPUTE, 1'b0, '0, '0, 1'b1, fxm_pkg::elem_t'(-1));
    add_row(fxm_pkg::KIND_LEFT, 1'b1, '0, fxm_pkg::ELEM_MAX, 1'b0, '0);
    add_row(fxm_pkg::KIND_RIGHT, 1'b1, '0, fxm_pkg::ELEM_MAX, 1'b0, '0);
    add_row(fxm_pkg::KIND_COMPUTE, 1'b0, '0, '0, 1'b1, fxm_pkg::ELEM_MAX);
    add_row(fxm_pkg::KIND_LEFT, 1'b1, '0, fxm_pkg::ELEM_MIN, 1'b0, '0);
    add_row(fxm_pkg::KIND_COMPUTE, 1'b0, '0, '0, 1'b1, fxm_pkg::ELEM_MIN);
    add_row(fxm_pkg::KIND_RIGHT, 1'b1, '0, fxm_pkg::ELEM_MIN, 1'b0, '0);
    add_row(fxm_pkg::KIND_COMPUTE, 1'b0, '0, '0, 1'b1, fxm_pkg::ELEM_MAX);
    add_row(fxm_pkg::KIND_LEFT, 1'b0, fxm_pkg::idx_t'(0), ONE_Q16, 1'b0, '0);
    add_row(fxm_pkg::KIND_LEFT, 1'b0, fxm_pkg::idx_t'(10), fxm_pkg::elem_t'(32'h0000_8000),
            1'b0, '0);
    add_row(fxm_pkg::KIND_RIGHT, 1'b0, fxm_pkg::IDX_LAST, '0, 1'b0, '0);
    add_row(fxm_pkg::KIND_RIGHT, 1'b0, fxm_pkg::idx_t'(5), -ONE_Q16, 1'b0, '0);
    add_row(fxm_pkg::KIND_COMPUTE, 1'b0, '0, '0, 1'b0, '0);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (stim_rows[n]) begin
      row = stim_rows[n];
      if (row.fill) begin
        for (int i = 0; i < fxm_pkg::CELLS; i++) begin
          send_word(row.kind, fxm_pkg::idx_t'(i), row.value);
          track_word(row.kind, fxm_pkg::idx_t'(i), row.value);
        end
      end else begin
        send_word(row.kind, row.index, row.value);
        if (row.kind == fxm_pkg::KIND_COMPUTE && row.typed) begin
          for (int k = 0; k < fxm_pkg::CELLS; k++) begin
            product_q.push_back('{index: fxm_pkg::idx_t'(k), value: row.want,
                                  last: (k == fxm_pkg::CELLS - 1)});
          end
        end else begin
          track_word(row.kind, row.index, row.value);
        end
      end
    end

    count = 0;
    paused = 1'b0;
    while (count < RANDOM_WORDS) begin
      if (count % 24 == 0) tx_burst = ($urandom_range(0, 5) == 0);
      roll = $urandom_range(0, 99);
      if (roll < 3) kind = KIND_UNUSED;
      else if (roll < 11) kind = fxm_pkg::KIND_COMPUTE;
      else if (roll < 56) kind = fxm_pkg::KIND_LEFT;
      else kind = fxm_pkg::KIND_RIGHT;
      index = fxm_pkg::idx_t'($urandom_range(0, fxm_pkg::CELLS - 1));
      value = pick_value();
      send_word(kind, index, value);
      track_word(kind, index, value);
      if (kind != KIND_UNUSED) count++;
      // Once, hold the input side until a whole product has been drained.
      if (!paused && kind == fxm_pkg::KIND_COMPUTE && count > RANDOM_WORDS / 2) begin
        paused = 1'b1;
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (product_q.size() != 0);
      end
    end
    in_ch.valid <= 1'b0;

    while (product_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (product_q.size() != 0) begin
      report_mismatch("result words never came", product_q.size(), '0);
    end
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
